[hw/rtl/assert_macros.svh]
// Assertion helpers, all clocked on clk and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold
`define AST_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: condition must never hold");

// ante implies cons in the same cycle
`define AST_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

// ante implies cons in the next cycle
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");

`endif

[hw/rtl/wsdf_pkg.sv]
package wsdf_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_ERROR = 2'd1,
        KIND_EMPTY = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DISCARD = 3'd5
    } phase_t;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [3:0] SKIP_16     = 4'd2;
    localparam logic [3:0] SKIP_64     = 4'd8;

    localparam logic [3:0] OP_CONT   = 4'd0;
    localparam logic [3:0] OP_TEXT   = 4'd1;
    localparam logic [3:0] OP_BINARY = 4'd2;
    localparam logic [3:0] OP_CLOSE  = 4'd8;
    localparam logic [3:0] OP_PING   = 4'd9;
    localparam logic [3:0] OP_PONG   = 4'd10;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_word_t;

    typedef struct packed {
        kind_t      out_kind;
        logic [7:0] out_byte;
        logic       out_fin;
        logic [3:0] out_opcode;
        logic       out_last;
    } out_word_t;

    // queued work: raw byte and key byte, XOR is done in the back end
    typedef struct packed {
        kind_t      kind;
        logic [7:0] raw;
        logic [7:0] key;
        logic       fin;
        logic [3:0] opcode;
        logic       last;
    } work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic opcode_valid(input logic [3:0] op);
        opcode_valid = (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BINARY) ||
                       (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
    endfunction

endpackage

[hw/rtl/websocket_frame_deframer_unmasker.sv]
// WebSocket receive-side deframer and unmasker.
// in channel (in_valid/in_ready/in_data): one byte of a received frame buffer
// per word, in_last set on the buffer's final byte. Header bytes, extended
// length bytes and the four mask-key bytes are consumed silently.
// out channel (out_valid/out_ready/out_data): one word per payload byte,
// unmasked, plus one error word for a reserved opcode or one empty-frame word
// when the buffer ends right after the key. out_last flags a frame's final word.
// A result word enters the queue when its byte is accepted, then the output
// register of out_valid. Throughput: one byte per cycle while the queue is not
// full; the four-entry queue and the output register decouple the sides.
// in_ready drops only when the queue is full, i.e. when the receiver has held
// out_ready low long enough; words are held, never dropped, during a stall.
// Reset clears the parser to expect header byte zero and empties the queue;
// no clearing pass is needed, the block accepts input right after reset.
module websocket_frame_deframer_unmasker
    import wsdf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    logic    take;
    logic    push;
    logic    pop;
    work_t   wrec;
    work_t   rrec;
    q_stat_t stat;

    assign in_ready = !stat.full;
    assign take     = in_valid && in_ready;

    wsdf_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .word  (in_data),
        .push  (push),
        .rec   (wrec)
    );

    wsdf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wrec),
        .pop   (pop),
        .rdata (rrec),
        .stat  (stat)
    );

    wsdf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .rdata     (rrec),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[hw/rtl/wsdf_front.sv]
`include "assert_macros.svh"

module wsdf_front
    import wsdf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  in_word_t word,
    output logic     push,
    output work_t    rec
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  skip_reg, skip_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  kidx_reg, kidx_next;
    logic        fin_reg, fin_next;
    logic [3:0]  op_reg, op_next;

    logic [7:0]  b;
    logic        last;
    logic [3:0]  hop;
    logic [1:0]  kidx_inc;
    logic [3:0]  skip_dec;

    assign b        = word.in_byte;
    assign last     = word.in_last;
    assign hop      = b[3:0];
    assign kidx_inc = kidx_reg + 2'd1;
    assign skip_dec = skip_reg - 4'd1;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        skip_next  = skip_reg;
        key_next   = key_reg;
        kidx_next  = kidx_reg;
        fin_next   = fin_reg;
        op_next    = op_reg;
        if (take)
        begin
            case (phase_reg)
                PH_HDR1:
                begin
                    if (last)
                    begin
                        phase_next = PH_HDR0;
                    end
                    else
                    begin
                        kidx_next = 2'd0;
                        key_next  = '0;
                        if (b[6:0] == LEN_CODE_16)
                        begin
                            skip_next  = SKIP_16;
                            phase_next = PH_EXTLEN;
                        end
                        else if (b[6:0] == LEN_CODE_64)
                        begin
                            skip_next  = SKIP_64;
                            phase_next = PH_EXTLEN;
                        end
                        else
                        begin
                            skip_next  = 4'd0;
                            phase_next = PH_KEY;
                        end
                    end
                end
                PH_EXTLEN:
                begin
                    if (last)
                    begin
                        phase_next = PH_HDR0;
                        skip_next  = 4'd0;
                    end
                    else
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == 4'd0)
                        begin
                            phase_next = PH_KEY;
                        end
                    end
                end
                PH_KEY:
                begin
                    key_next[kidx_reg*8 +: 8] = key_reg[kidx_reg*8 +: 8] | b;
                    kidx_next = kidx_inc;
                    if (kidx_inc == 2'd0)
                    begin
                        phase_next = last ? PH_HDR0 : PH_PAYLOAD;
                    end
                    else if (last)
                    begin
                        phase_next = PH_HDR0;
                        kidx_next  = 2'd0;
                    end
                end
                PH_PAYLOAD:
                begin
                    kidx_next = kidx_inc;
                    if (last)
                    begin
                        phase_next = PH_HDR0;
                        kidx_next  = 2'd0;
                    end
                end
                PH_DISCARD:
                begin
                    if (last)
                    begin
                        phase_next = PH_HDR0;
                    end
                end
                default:
                begin
                    fin_next = b[7];
                    op_next  = hop;
                    if (!opcode_valid(hop))
                    begin
                        phase_next = last ? PH_HDR0 : PH_DISCARD;
                    end
                    else
                    begin
                        phase_next = last ? PH_HDR0 : PH_HDR1;
                    end
                end
            endcase
        end
    end

    // results
    always_comb
    begin
        push       = 1'b0;
        rec.kind   = KIND_DATA;
        rec.raw    = 8'd0;
        rec.key    = 8'd0;
        rec.fin    = fin_reg;
        rec.opcode = op_reg;
        rec.last   = 1'b1;
        case (phase_reg)
            PH_HDR1, PH_EXTLEN, PH_DISCARD:
            begin
                push = 1'b0;
            end
            PH_KEY:
            begin
                push     = take && (kidx_inc == 2'd0) && last;
                rec.kind = KIND_EMPTY;
            end
            PH_PAYLOAD:
            begin
                push     = take;
                rec.kind = KIND_DATA;
                rec.raw  = b;
                rec.key  = key_reg[kidx_reg*8 +: 8];
                rec.last = last;
            end
            default:
            begin
                push       = take && !opcode_valid(hop);
                rec.kind   = KIND_ERROR;
                rec.fin    = b[7];
                rec.opcode = hop;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR0;
            skip_reg  <= 4'd0;
            key_reg   <= '0;
            kidx_reg  <= 2'd0;
            fin_reg   <= 1'b0;
            op_reg    <= 4'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            key_reg   <= key_next;
            kidx_reg  <= kidx_next;
            fin_reg   <= fin_next;
            op_reg    <= op_next;
        end
    end

    `AST_IMPLY(a_err_ends_frame, push && rec.kind == KIND_ERROR, rec.last)
    `AST_NEXT(a_payload_wraps, take && phase_reg == PH_PAYLOAD && last, kidx_reg == 2'd0)

endmodule

[hw/rtl/wsdf_queue.sv]
`include "assert_macros.svh"

module wsdf_queue
    import wsdf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  work_t   wdata,
    input  logic    pop,
    output work_t   rdata,
    output q_stat_t stat
);

    work_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign rdata      = mem_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    `AST_NEVER(a_no_overflow, push && stat.full)
    `AST_NEVER(a_no_underflow, pop && stat.empty)

endmodule

[hw/rtl/wsdf_back.sv]
`include "assert_macros.svh"

module wsdf_back
    import wsdf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_stat_t   stat,
    input  work_t     rdata,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    logic      valid_reg;
    out_word_t data_reg, data_next;

    assign pop       = !stat.empty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next.out_kind   = rdata.kind;
        data_next.out_byte   = rdata.raw ^ rdata.key;
        data_next.out_fin    = rdata.fin;
        data_next.out_opcode = rdata.opcode;
        data_next.out_last   = rdata.last;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    `AST_NEXT(a_pop_loads, pop, valid_reg)

endmodule

[verif/websocket_deframe_checker.sv]
`timescale 1ns / 1ps

module websocket_deframe_checker
    import wsdf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_word_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_word_t out_data,
    output int        fail_count,
    output int        pending_words
);

    // predicted parser state
    phase_t     rx_phase;
    logic [3:0] ext_left;
    logic [31:0] key_reg;
    logic [1:0] key_pos;
    logic       hdr_fin;
    logic [3:0] hdr_op;

    out_word_t  expected_words[$];

    initial begin
        fail_count = 0;
        pending_words = 0;
    end

    function automatic bit is_known_opcode(input logic [3:0] op);
        case (op)
            OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic out_word_t make_word(input kind_t k, input logic [7:0] data,
                                            input logic last);
        out_word_t w;
        w.out_kind   = k;
        w.out_byte   = data;
        w.out_fin    = hdr_fin;
        w.out_opcode = hdr_op;
        w.out_last   = last;
        return w;
    endfunction

    function automatic void unmask_byte(input in_word_t w, output bit has_word,
                                        output out_word_t word);
        has_word = 1'b0;
        word = '0;
        case (rx_phase)
            PH_HDR1:
                if (w.in_last)
                    rx_phase = PH_HDR0;
                else
                begin
                    key_reg = '0;
                    key_pos = '0;
                    if (w.in_byte[6:0] == LEN_CODE_16)
                    begin
                        ext_left = SKIP_16;
                        rx_phase = PH_EXTLEN;
                    end
                    else if (w.in_byte[6:0] == LEN_CODE_64)
                    begin
                        ext_left = SKIP_64;
                        rx_phase = PH_EXTLEN;
                    end
                    else
                    begin
                        ext_left = '0;
                        rx_phase = PH_KEY;
                    end
                end
            PH_EXTLEN:
                if (w.in_last)
                begin
                    rx_phase = PH_HDR0;
                    ext_left = '0;
                end
                else
                begin
                    ext_left = ext_left - 4'd1;
                    if (ext_left == 4'd0)
                        rx_phase = PH_KEY;
                end
            PH_KEY:
            begin
                key_reg[key_pos*8 +: 8] = w.in_byte;
                key_pos = key_pos + 2'd1;
                if (key_pos == 2'd0)
                begin
                    if (w.in_last)
                    begin
                        rx_phase = PH_HDR0;
                        has_word = 1'b1;
                        word = make_word(KIND_EMPTY, 8'h00, 1'b1);
                    end
                    else
                        rx_phase = PH_PAYLOAD;
                end
                else if (w.in_last)
                begin
                    rx_phase = PH_HDR0;
                    key_pos = '0;
                end
            end
            PH_PAYLOAD:
            begin
                has_word = 1'b1;
                word = make_word(KIND_DATA, w.in_byte ^ key_reg[key_pos*8 +: 8], w.in_last);
                key_pos = key_pos + 2'd1;
                if (w.in_last)
                begin
                    rx_phase = PH_HDR0;
                    key_pos = '0;
                end
            end
            PH_DISCARD:
                if (w.in_last)
                    rx_phase = PH_HDR0;
            default:
            begin
                // header byte zero; unused phase codes land here too
                hdr_fin = w.in_byte[7];
                hdr_op  = w.in_byte[3:0];
                if (!is_known_opcode(hdr_op))
                begin
                    rx_phase = w.in_last ? PH_HDR0 : PH_DISCARD;
                    has_word = 1'b1;
                    word = make_word(KIND_ERROR, 8'h00, 1'b1);
                end
                else
                    rx_phase = w.in_last ? PH_HDR0 : PH_HDR1;
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bit        has_word;
        out_word_t word;
        out_word_t exp_w;
        if (!rst_n)
        begin
            rx_phase = PH_HDR0;
            ext_left = '0;
            key_reg  = '0;
            key_pos  = '0;
            hdr_fin  = 1'b0;
            hdr_op   = '0;
            expected_words.delete();
            pending_words = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                unmask_byte(in_data, has_word, word);
                if (has_word)
                    expected_words.push_back(word);
            end
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, got kind %0d byte %0h last %0b",
                             $time, out_data.out_kind, out_data.out_byte, out_data.out_last);
                    fail_count++;
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    check_field("out_kind", exp_w.out_kind, out_data.out_kind);
                    check_field("out_byte", exp_w.out_byte, out_data.out_byte);
                    check_field("out_fin", exp_w.out_fin, out_data.out_fin);
                    check_field("out_opcode", exp_w.out_opcode, out_data.out_opcode);
                    check_field("out_last", exp_w.out_last, out_data.out_last);
                end
            end
            pending_words = expected_words.size();
        end
    end

endmodule

[verif/tb_websocket_frame_deframer_unmasker.sv]
`timescale 1ns / 1ps

module tb_websocket_frame_deframer_unmasker;
    import wsdf_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int STALL_CYCLES = 50;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_data;

    int fail_count;
    int pending_words;

    int send_idle_pct = 15;
    int recv_idle_pct = 60;
    bit stall_req = 1'b0;
    int hold_left = 0;
    int bytes_sent = 0;
    int quiet_cycles = 0;

    logic [7:0] payload_q[$];
    logic [3:0] good_ops[6] = '{OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG};

    websocket_frame_deframer_unmasker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    websocket_deframe_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // receiver: random backpressure, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_req)
            begin
                hold_left = STALL_CYCLES;
                stall_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // entered right after the edge that took the previous word
    task automatic send_word(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= '{in_byte: b, in_last: last};
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    // cut > 0 ends the buffer early after that many bytes
    task automatic send_frame(input logic [7:0] hdr0, input logic [7:0] hdr1,
                              input logic [31:0] key, input int cut);
        logic [7:0] frame_bytes[$];
        int ext_n;
        int n;
        frame_bytes = {hdr0, hdr1};
        ext_n = (hdr1[6:0] == LEN_CODE_16) ? SKIP_16 :
                (hdr1[6:0] == LEN_CODE_64) ? SKIP_64 : 0;
        repeat (ext_n) frame_bytes.push_back(8'($urandom));
        for (int k = 0; k < 4; k++) frame_bytes.push_back(key[k*8 +: 8]);
        foreach (payload_q[i]) frame_bytes.push_back(payload_q[i]);
        n = frame_bytes.size();
        if (cut > 0 && cut < n)
            n = cut;
        for (int i = 0; i < n; i++)
            send_word(frame_bytes[i], i == n - 1);
    endtask

    task automatic fill_payload(input int n);
        payload_q.delete();
        repeat (n) payload_q.push_back(8'($urandom));
    endtask

    task automatic random_frame();
        logic [7:0] hdr0;
        logic [7:0] hdr1;
        int r;
        hdr0 = 8'($urandom);
        if ($urandom_range(99) < 80)
            hdr0[3:0] = good_ops[$urandom_range(5)];
        hdr1 = 8'($urandom);
        r = $urandom_range(99);
        if (r < 70)
            hdr1[6:0] = 7'($urandom_range(125));
        else if (r < 85)
            hdr1[6:0] = LEN_CODE_16;
        else
            hdr1[6:0] = LEN_CODE_64;
        fill_payload(($urandom_range(99) < 10) ? $urandom_range(40, 13) : $urandom_range(12));
        send_frame(hdr0, hdr1, $urandom,
                   ($urandom_range(99) < 15) ? $urandom_range(20, 1) : 0);
    endtask

    task automatic run_random(input int budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < budget)
            random_frame();
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_words == 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // masked text frame, byte extremes across key positions
        payload_q = {8'hFF, 8'h00, 8'h5A};
        send_frame(8'h81, 8'h83, 32'h00FF_A5C3, 0);
        // close frame ending on the last key byte
        payload_q.delete();
        send_frame(8'h88, 8'h80, 32'hFFFF_FFFF, 0);
        // reserved opcodes: alone, and followed by discarded bytes
        send_word(8'h73, 1'b1);
        send_word(8'h8F, 1'b0);
        send_word(8'hFF, 1'b1);
        // truncated on header byte zero, in the 16-bit length, in the key
        send_word(8'h09, 1'b1);
        send_frame(8'h02, 8'hFE, 32'h1234_5678, 3);
        send_frame(8'h0A, 8'h05, 32'h8765_4321, 5);

        run_random(125);
        drain();

        send_idle_pct = 60;
        recv_idle_pct = 15;
        run_random(125);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_req = 1'b1;
        fill_payload(30);
        send_frame(8'h82, 8'h1E, $urandom, 0);
        run_random(125);

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
